// File: hw/rtl/h264_fu_a_packetizer_macros.svh
// ----------------------------------------------------------------------------
// h264_fu_a_packetizer_macros
// assertion macros shared by the fu-a packetizer rtl
// ----------------------------------------------------------------------------
`ifndef H264_FU_A_PACKETIZER_MACROS_SVH
`define H264_FU_A_PACKETIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define H264FU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define H264FU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/h264fu_pkg.sv
// ----------------------------------------------------------------------------
// h264fu_pkg
// types and constants of the h.264 fu-a packetizer
// ----------------------------------------------------------------------------
package h264fu_pkg;

  localparam int UNIT_LENGTH_W = 24;

  localparam logic [4:0]  FU_A_TYPE       = 5'd28;
  localparam logic [15:0] MIN_PACKET_SIZE = 16'd4;
  localparam logic [15:0] RESET_PACKET_SIZE = 16'd1200;

  typedef struct packed {
    logic [7:0]               data_byte;
    logic                     unit_start;
    logic [UNIT_LENGTH_W-1:0] unit_length;
  } h264fu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       run_last;
  } h264fu_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_COUNT,
    ST_DIV_SIZE,
    ST_EMIT
  } h264fu_state_t;

endpackage

// File: hw/rtl/h264_fu_a_packetizer.sv
// ----------------------------------------------------------------------------
// h264_fu_a_packetizer
// splits h.264 nal units into balanced fu-a packets
// ----------------------------------------------------------------------------
// in_*  : one nal unit byte per transaction, unit_length read on unit_start
// out_* : one packet byte per transaction, with packet start/end marks and
//         run_last on the final result of each input transaction
// cfg_* : writes max_packet_size; the user must write it only while the block is idle, the block does not enforce it
// a pass-through byte or a fragment payload byte gives one result; the
// first payload byte of a fragment gives three (indicator, fu header, byte)
// the first result is registered and shown in the cycle after the input transaction
// the header byte of a fragmented unit runs two divisions on the shared
// restoring divider, first the packet count and then the balanced
// fragment size, and gives no result
// in_ready is low while results are pending or the divider is busy
// a stalled receiver simply holds the pending result and the input side
// reset clears the unit state but len_r and the result buffer, and sets max_packet_size to 1200
// ----------------------------------------------------------------------------
`include "h264_fu_a_packetizer_macros.svh"

module h264_fu_a_packetizer
  import h264fu_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  h264fu_in_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output h264fu_out_t out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int LW = LENGTH_BITS;
  localparam int DW = LENGTH_BITS + 1;

  h264fu_state_t state_r, state_nxt;

  logic [15:0]   max_r;
  logic [7:0]    saved_r, saved_nxt;
  logic          frag_r, frag_nxt;
  logic [LW-1:0] pl_r, pl_nxt;
  logic [15:0]   fps_r, fps_nxt;
  logic [15:0]   bif_r, bif_nxt;
  logic [LW-1:0] off_r, off_nxt;
  logic [LW-1:0] len_r, len_nxt;

  h264fu_out_t   em_r [3];
  h264fu_out_t   em_nxt [3];
  logic [1:0]    em_cnt_r, em_cnt_nxt;
  logic [1:0]    em_idx_r, em_idx_nxt;

  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_dvd;
  logic [DW-1:0] div_dvs;
  logic [DW-1:0] div_q;

  logic [LW+UNIT_LENGTH_W-1:0] len_ext;
  logic [LW-1:0] len_in;
  logic [LW-1:0] len_eff;
  logic [15:0]   m_eff;
  logic          in_acc;
  logic          out_acc;
  logic          em_last;
  logic [7:0]    fu_ind;
  logic [7:0]    fu_hdr;
  logic [LW-1:0] pl_dec;
  logic [15:0]   bif_inc;
  logic          frag_done;

  h264fu_divider #(
    .W(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign cfg_ready = 1'b1;
  assign out_data  = em_r[em_idx_r];

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign em_last = (em_idx_r == em_cnt_r - 2'd1);

  assign len_ext = {{LW{1'b0}}, in_data.unit_length};
  assign len_in  = len_ext[LW-1:0];
  assign len_eff = (len_in == '0) ? LW'(1) : len_in;
  assign m_eff   = (max_r < MIN_PACKET_SIZE) ? MIN_PACKET_SIZE : max_r;

  assign fu_ind    = {saved_r[7:5], FU_A_TYPE};
  assign fu_hdr    = {(off_r == '0), (off_r != '0) && (pl_r <= LW'(fps_r)), 1'b0,
                      saved_r[4:0]};
  assign pl_dec    = pl_r - LW'(1);
  assign bif_inc   = bif_r + 16'd1;
  assign frag_done = (bif_inc >= fps_r) || (pl_dec == '0);

  // divider operands: unit count first, then balanced fragment size
  always_comb begin
    if (state_r == ST_DIV_COUNT) begin
      div_dvd = DW'(len_r) + div_q - DW'(1);
      div_dvs = div_q;
    end else begin
      div_dvd = DW'(len_eff) + DW'(m_eff) - DW'(1);
      div_dvs = DW'(m_eff);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    saved_nxt  = saved_r;
    frag_nxt   = frag_r;
    pl_nxt     = pl_r;
    fps_nxt    = fps_r;
    bif_nxt    = bif_r;
    off_nxt    = off_r;
    len_nxt    = len_r;
    em_nxt     = em_r;
    em_cnt_nxt = em_cnt_r;
    em_idx_nxt = em_idx_r;
    div_start  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          em_idx_nxt = 2'd0;
          if (in_data.unit_start) begin
            pl_nxt  = len_eff - LW'(1);
            bif_nxt = '0;
            off_nxt = '0;
            len_nxt = len_eff;
            if (len_eff <= LW'(m_eff)) begin
              frag_nxt   = 1'b0;
              em_nxt[0]  = '{out_byte: in_data.data_byte, packet_start: 1'b1,
                             packet_end: (len_eff == LW'(1)), run_last: 1'b1};
              em_cnt_nxt = 2'd1;
              state_nxt  = ST_EMIT;
            end else begin
              frag_nxt  = 1'b1;
              saved_nxt = in_data.data_byte;
              div_start = 1'b1;
              state_nxt = ST_DIV_COUNT;
            end
          end else if (pl_r == '0) begin
            state_nxt = ST_IDLE;
          end else if (!frag_r) begin
            em_nxt[0]  = '{out_byte: in_data.data_byte, packet_start: 1'b0,
                           packet_end: (pl_r == LW'(1)), run_last: 1'b1};
            em_cnt_nxt = 2'd1;
            pl_nxt     = pl_dec;
            state_nxt  = ST_EMIT;
          end else begin
            pl_nxt    = pl_dec;
            off_nxt   = off_r + LW'(1);
            bif_nxt   = frag_done ? 16'd0 : bif_inc;
            state_nxt = ST_EMIT;
            if (frag_done && (pl_dec == '0)) begin
              frag_nxt = 1'b0;
            end
            if (bif_r == '0) begin
              em_nxt[0]  = '{out_byte: fu_ind, packet_start: 1'b1,
                             packet_end: 1'b0, run_last: 1'b0};
              em_nxt[1]  = '{out_byte: fu_hdr, packet_start: 1'b0,
                             packet_end: 1'b0, run_last: 1'b0};
              em_nxt[2]  = '{out_byte: in_data.data_byte, packet_start: 1'b0,
                             packet_end: frag_done, run_last: 1'b1};
              em_cnt_nxt = 2'd3;
            end else begin
              em_nxt[0]  = '{out_byte: in_data.data_byte, packet_start: 1'b0,
                             packet_end: frag_done, run_last: 1'b1};
              em_cnt_nxt = 2'd1;
            end
          end
        end
      end
      ST_DIV_COUNT: begin
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_SIZE;
        end
      end
      ST_DIV_SIZE: begin
        if (div_done) begin
          fps_nxt   = 16'(div_q - DW'(2));
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (em_last) begin
            state_nxt = ST_IDLE;
          end else begin
            em_idx_nxt = em_idx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      max_r    <= RESET_PACKET_SIZE;
      saved_r  <= '0;
      frag_r   <= 1'b0;
      pl_r     <= '0;
      fps_r    <= '0;
      bif_r    <= '0;
      off_r    <= '0;
      em_cnt_r <= 2'd1;
      em_idx_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      saved_r  <= saved_nxt;
      frag_r   <= frag_nxt;
      pl_r     <= pl_nxt;
      fps_r    <= fps_nxt;
      bif_r    <= bif_nxt;
      off_r    <= off_nxt;
      em_cnt_r <= em_cnt_nxt;
      em_idx_r <= em_idx_nxt;
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    em_r  <= em_nxt;
  end

  `H264FU_ASSERT_NOW(a_no_accept_while_emitting, clk, rst_n, out_valid, !in_ready,
                     "input accepted while results pending")
  `H264FU_ASSERT_NEXT(a_count_then_size, clk, rst_n, (state_r == ST_DIV_COUNT) && div_done,
                      state_r == ST_DIV_SIZE, "size division did not follow count division")
  `H264FU_ASSERT_NEXT(a_last_result_frees_input, clk, rst_n, out_acc && out_data.run_last,
                      in_ready, "input not released after last result")

endmodule

// File: hw/rtl/h264fu_divider.sv
// ----------------------------------------------------------------------------
// h264fu_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module h264fu_divider #(
  parameter int W = 25
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dvd_r;
  logic [W-1:0]  dvs_r;
  logic [W-1:0]  rem_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  assign trial = {rem_r, dvd_r[W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        cnt_r <= CW'(W);
      end else if (cnt_r != '0) begin
        rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
        dvd_r <= {dvd_r[W-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the h.264 fu-a packetizer: nal units of random
// content are streamed in under random idling on both sides, every output
// transaction is checked against an in-bench model of the fragmentation,
// and max_packet_size is swept from below the minimum up to 65535
// ----------------------------------------------------------------------------
module testbench;
  import h264fu_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  h264fu_in_t  in_data;
  logic        out_valid;
  logic        out_ready;
  h264fu_out_t out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  h264_fu_a_packetizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  h264fu_in_t  nal_bytes_pending[$];
  h264fu_out_t expected_packet_bytes[$];
  h264fu_out_t want;

  int in_idle_pct;
  int out_idle_pct;
  int in_gap;
  int out_stall;
  int mismatch_count;

  // packetizer model state
  logic [15:0] pkt_max;
  logic [7:0]  hdr_keep;
  logic        frag_on;
  logic [23:0] bytes_left;
  logic [15:0] frag_size;
  logic [15:0] frag_fill;
  logic [23:0] frag_pos;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic h264fu_out_t pkt_result(input logic [7:0] b, input logic ps,
                                             input logic pe);
    h264fu_out_t r;
    r.out_byte     = b;
    r.packet_start = ps;
    r.packet_end   = pe;
    r.run_last     = 1'b0;
    return r;
  endfunction

  function automatic void packetize_byte(input h264fu_in_t it);
    h264fu_out_t       res[$];
    longint unsigned   len;
    longint unsigned   lim;
    longint unsigned   cnt;
    longint unsigned   sz;
    logic              s_bit;
    logic              e_bit;
    logic              closed;
    if (it.unit_start) begin
      len = 64'(it.unit_length);
      lim = 64'((pkt_max < MIN_PACKET_SIZE) ? MIN_PACKET_SIZE : pkt_max);
      if (len == 0) len = 1;
      bytes_left = 24'(len - 1);
      frag_fill  = '0;
      frag_pos   = '0;
      if (len <= lim) begin
        frag_on = 1'b0;
        res = {res, pkt_result(it.data_byte, 1'b1, len == 1)};
      end else begin
        cnt       = (len + lim - 1) / lim;
        sz        = (len + cnt - 1) / cnt - 2;
        frag_on   = 1'b1;
        hdr_keep  = it.data_byte;
        frag_size = sz[15:0];
      end
    end else if (bytes_left != 0) begin
      if (!frag_on) begin
        res = {res, pkt_result(it.data_byte, 1'b0, bytes_left == 1)};
        bytes_left--;
      end else begin
        if (frag_fill == 0) begin
          s_bit = (frag_pos == 0);
          e_bit = (frag_pos != 0) && (bytes_left <= frag_size);
          res = {res, pkt_result({hdr_keep[7:5], FU_A_TYPE}, 1'b1, 1'b0)};
          res = {res, pkt_result({s_bit, e_bit, 1'b0, hdr_keep[4:0]}, 1'b0, 1'b0)};
        end
        frag_fill++;
        frag_pos++;
        bytes_left--;
        closed = (frag_fill >= frag_size) || (bytes_left == 0);
        res = {res, pkt_result(it.data_byte, 1'b0, closed)};
        if (closed) begin
          frag_fill = '0;
          if (bytes_left == 0) frag_on = 1'b0;
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    expected_packet_bytes = {expected_packet_bytes, res};
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap = 0;
      hdr_keep   = '0;
      frag_on    = 1'b0;
      bytes_left = '0;
      frag_size  = '0;
      frag_fill  = '0;
      frag_pos   = '0;
    end else begin
      if (in_valid && in_ready) packetize_byte(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (nal_bytes_pending.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= nal_bytes_pending.pop_front();
          if ($urandom_range(0, 99) < in_idle_pct) in_gap = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_packet_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transaction: byte %h start %b end %b last %b",
                     out_data.out_byte, out_data.packet_start, out_data.packet_end,
                     out_data.run_last);
        end else begin
          want = expected_packet_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.packet_start !== want.packet_start ||
              out_data.packet_end !== want.packet_end ||
              out_data.run_last !== want.run_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected byte %h start %b end %b last %b, %s %h %b %b %b",
                       want.out_byte, want.packet_start, want.packet_end, want.run_last,
                       "got", out_data.out_byte, out_data.packet_start,
                       out_data.packet_end, out_data.run_last);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < out_idle_pct) out_stall = $urandom_range(1, 3);
      end
    end
  end

  function automatic void add_stray(input logic [7:0] b, input logic [23:0] field);
    h264fu_in_t it;
    it.data_byte   = b;
    it.unit_start  = 1'b0;
    it.unit_length = field;
    nal_bytes_pending = {nal_bytes_pending, it};
  endfunction

  function automatic void add_unit(input logic [7:0] hdr, input logic [23:0] field,
                                   input int nbytes);
    h264fu_in_t it;
    it.data_byte   = hdr;
    it.unit_start  = 1'b1;
    it.unit_length = field;
    nal_bytes_pending = {nal_bytes_pending, it};
    for (int k = 1; k < nbytes; k++)
      add_stray(8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)));
  endfunction

  function automatic void random_units(input int items);
    int          made;
    int          lim;
    int          cap;
    int          len;
    int          pick;
    logic [23:0] field;
    made = 0;
    lim  = int'((pkt_max < MIN_PACKET_SIZE) ? MIN_PACKET_SIZE : pkt_max);
    cap  = (3 * lim + 3 < 48) ? 3 * lim + 3 : 48;
    while (made < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        add_stray(8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)));
      end else if (pick < 18) begin
        // unit abandoned by the next start
        len   = $urandom_range(1, 8);
        field = 24'($urandom_range(len + 1, 24'hFFFFFF));
        add_unit(8'($urandom_range(0, 255)), field, len);
        made += len;
      end else if (pick < 21) begin
        add_unit(8'($urandom_range(0, 255)), 24'd0, 1);
        made++;
      end else begin
        len = $urandom_range(1, cap);
        add_unit(8'($urandom_range(0, 255)), 24'(len), len);
        made += len;
      end
    end
  endfunction

  task automatic settle();
    while (nal_bytes_pending.size() != 0 || in_valid || expected_packet_bytes.size() != 0)
      @(negedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    pkt_max = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] sizes [8];
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    in_idle_pct    = 30;
    out_idle_pct   = 30;
    pkt_max    = RESET_PACKET_SIZE;
    sizes = '{16'd0, 16'd4, 16'd5, 16'd7, 16'd13, 16'd40, 16'hFFFF, 16'd1200};
    sizes[5] = 16'($urandom_range(4, 300));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size: stray byte, zero length, one-byte unit, short pass-through
    add_stray(8'hA5, 24'hFFFFFF);
    add_unit(8'hFF, 24'd0, 1);
    add_unit(8'h00, 24'd1, 1);
    add_unit(8'h65, 24'd3, 3);
    add_stray(8'h00, 24'd0);

    // size below the minimum, fragmentation and restart inside a unit
    settle();
    write_max(16'd3);
    add_unit(8'hFF, 24'd9, 9);
    add_unit(8'h7C, 24'hFFFFFF, 3);
    add_unit(8'h00, 24'd4, 4);

    settle();
    write_max(16'hFFFF);
    add_unit(8'h80, 24'hFFFFFF, 3);
    add_unit(8'h1F, 24'd2, 2);

    for (int i = 0; i < 8; i++) begin
      settle();
      write_max(sizes[i]);
      if (i == 7) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = $urandom_range(0, 3) * 15;
        out_idle_pct = $urandom_range(0, 3) * 15;
      end
      random_units(62);
    end

    settle();
    if (mismatch_count == 0 && expected_packet_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
